// ----- sv/etl_pkg.sv -----
// Package with the constants and helper functions of the two-level cache tag store.
package etl_pkg;

  localparam int unsigned AddrBitsDef  = 32;
  localparam int unsigned LineBytesDef = 64;
  localparam int unsigned L1SetsDef    = 64;
  localparam int unsigned L1WaysDef    = 8;
  localparam int unsigned L2SetsDef    = 1024;
  localparam int unsigned L2WaysDef    = 16;
  localparam int unsigned InAddrBits   = 32;
  localparam int unsigned StatusBits   = 2;

  localparam logic [StatusBits-1:0] StatusL1Hit  = 2'd0;
  localparam logic [StatusBits-1:0] StatusL2Hit  = 2'd1;
  localparam logic [StatusBits-1:0] StatusMiss   = 2'd2;

endpackage

// ----- sv/exclusive_two_level_lru_cache_top.sv -----
// Top level of the exclusive two-level set-associative LRU cache tag store.
//
// The block takes one byte address per transfer and returns one status per
// address: L1 hit, L1 miss with L2 hit, or miss in both levels. L1 and L2 each
// keep one row per set in a memory (line addresses or tags, valid bits and LRU
// ranks packed in a row). An access is handled by a small sequencer that works
// on one address at a time and is not ready meanwhile: read the L1 row, compare
// all ways and pick the victim, read the requested L2 row, write back the L2
// row with any hit invalidated, read the victim's L2 row, write it with the
// victim installed, and finally write the L1 row. An L1 hit skips the L2
// steps; the victim's L2 row is read and written only when a valid L1 victim
// has to move into L2. After reset both memories are cleared one row per
// cycle, and no address is accepted until every row of both is cleared. The
// result sits in an output register and waits there until it is taken. The
// next address may be accepted while it waits; the sequencer then holds in
// its last step until the output register is free.
module exclusive_two_level_lru_cache_top #(
  parameter int unsigned ADDR_BITS  = etl_pkg::AddrBitsDef,
  parameter int unsigned LINE_BYTES = etl_pkg::LineBytesDef,
  parameter int unsigned L1_SETS    = etl_pkg::L1SetsDef,
  parameter int unsigned L1_WAYS    = etl_pkg::L1WaysDef,
  parameter int unsigned L2_SETS    = etl_pkg::L2SetsDef,
  parameter int unsigned L2_WAYS    = etl_pkg::L2WaysDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [etl_pkg::InAddrBits-1:0]    address_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [etl_pkg::StatusBits-1:0]    status_o
);

  localparam int unsigned OffBits  = $clog2(LINE_BYTES);
  localparam int unsigned UseBits  = (ADDR_BITS < etl_pkg::InAddrBits) ? ADDR_BITS
                                                                        : etl_pkg::InAddrBits;
  localparam int unsigned LineBits = UseBits - OffBits;
  localparam int unsigned S1Bits   = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int unsigned S2Bits   = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int unsigned S2Shift  = $clog2(L2_SETS);
  localparam int unsigned TagBits  = (LineBits > S2Shift) ? LineBits - S2Shift : 1;
  localparam int unsigned W1Bits   = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int unsigned W2Bits   = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int unsigned ClrSets  = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
  localparam int unsigned ClrBits  = $clog2(ClrSets + 1);
  localparam int unsigned StatusBits_w = etl_pkg::StatusBits;

  typedef struct packed {
    logic [L1_WAYS-1:0][LineBits-1:0] line;
    logic [L1_WAYS-1:0]               valid;
    logic [L1_WAYS-1:0][W1Bits-1:0]   rank;
  } l1_row_t;

  typedef struct packed {
    logic [L2_WAYS-1:0][TagBits-1:0] tag;
    logic [L2_WAYS-1:0]              valid;
    logic [L2_WAYS-1:0][W2Bits-1:0]  rank;
  } l2_row_t;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StRd1   = 4'd2;
  localparam logic [3:0] StCmp1  = 4'd3;
  localparam logic [3:0] StRd2   = 4'd4;
  localparam logic [3:0] StWr2   = 4'd5;
  localparam logic [3:0] StRdV   = 4'd6;
  localparam logic [3:0] StWrV   = 4'd7;
  localparam logic [3:0] StWr1   = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  logic [3:0]               state_q, state_d;
  logic [ClrBits-1:0]       clr_q, clr_d;
  logic [LineBits-1:0]      line_q;
  logic [StatusBits_w-1:0]  res_q;
  logic [StatusBits_w-1:0]  status_q;
  logic                     out_valid_q;

  l1_row_t l1_mem [L1_SETS];
  l2_row_t l2_mem [L2_SETS];
  l1_row_t l1_rd_q, l1_new_q;
  l2_row_t l2_rd_q;
  logic    vict_valid_q;
  logic [LineBits-1:0] vict_line_q;

  // Set indexes.
  logic [S1Bits-1:0] set1;
  logic [S2Bits-1:0] set2, setv;
  logic [TagBits-1:0] tag2, tagv;
  logic [LineBits-1:0] in_line;

  assign in_line = address_i[UseBits-1:OffBits];
  assign set1 = (L1_SETS > 1) ? S1Bits'(line_q) : '0;
  assign set2 = (L2_SETS > 1) ? S2Bits'(line_q) : '0;
  assign setv = (L2_SETS > 1) ? S2Bits'(vict_line_q) : '0;
  assign tag2 = TagBits'(line_q >> S2Shift);
  assign tagv = TagBits'(vict_line_q >> S2Shift);

  // L1 compare and victim choice on the registered row.
  logic              hit1;
  logic [W1Bits-1:0] hit_w, vic_w, tgt_w;
  logic              any_inv;
  l1_row_t           l1_upd;

  always_comb begin
    hit1    = 1'b0;
    hit_w   = '0;
    any_inv = 1'b0;
    vic_w   = '0;
    for (int i = L1_WAYS - 1; i >= 0; i--) begin
      if (l1_rd_q.valid[i] && l1_rd_q.line[i] == line_q) begin
        hit1  = 1'b1;
        hit_w = W1Bits'(i);
      end
      if (!l1_rd_q.valid[i]) begin
        any_inv = 1'b1;
        vic_w   = W1Bits'(i);
      end
    end
    if (!any_inv) begin
      for (int i = 0; i < L1_WAYS; i++) begin
        if (l1_rd_q.rank[i] == W1Bits'(L1_WAYS - 1)) begin
          vic_w = W1Bits'(i);
        end
      end
    end
    tgt_w  = hit1 ? hit_w : vic_w;
    l1_upd = l1_rd_q;
    for (int i = 0; i < L1_WAYS; i++) begin
      if (l1_rd_q.rank[i] < l1_rd_q.rank[tgt_w]) begin
        l1_upd.rank[i] = l1_rd_q.rank[i] + 1'b1;
      end
    end
    l1_upd.rank[tgt_w]  = '0;
    l1_upd.line[tgt_w]  = line_q;
    l1_upd.valid[tgt_w] = 1'b1;
  end

  // L2 lookup on the requested set: invalidate a matching way.
  logic    hit2;
  l2_row_t l2_inv;
  always_comb begin
    hit2   = 1'b0;
    l2_inv = l2_rd_q;
    for (int i = 0; i < L2_WAYS; i++) begin
      if (!hit2 && l2_rd_q.valid[i] && l2_rd_q.tag[i] == tag2) begin
        hit2 = 1'b1;
        l2_inv.valid[i] = 1'b0;
      end
    end
  end

  // L2 install of the L1 victim in its own set.
  logic [W2Bits-1:0] u_w;
  logic              inv2;
  l2_row_t           l2_ins;
  always_comb begin
    inv2 = 1'b0;
    u_w  = '0;
    for (int i = L2_WAYS - 1; i >= 0; i--) begin
      if (!l2_rd_q.valid[i]) begin
        inv2 = 1'b1;
        u_w  = W2Bits'(i);
      end
    end
    if (!inv2) begin
      for (int i = 0; i < L2_WAYS; i++) begin
        if (l2_rd_q.rank[i] == W2Bits'(L2_WAYS - 1)) begin
          u_w = W2Bits'(i);
        end
      end
    end
    l2_ins = l2_rd_q;
    for (int i = 0; i < L2_WAYS; i++) begin
      if (l2_rd_q.rank[i] < l2_rd_q.rank[u_w]) begin
        l2_ins.rank[i] = l2_rd_q.rank[i] + 1'b1;
      end
    end
    l2_ins.rank[u_w]  = '0;
    l2_ins.tag[u_w]   = tagv;
    l2_ins.valid[u_w] = 1'b1;
  end

  // Reset rows: all invalid, ranks in way order.
  l1_row_t l1_clr;
  l2_row_t l2_clr;
  always_comb begin
    l1_clr = '0;
    l2_clr = '0;
    for (int i = 0; i < L1_WAYS; i++) l1_clr.rank[i] = W1Bits'(i);
    for (int i = 0; i < L2_WAYS; i++) l2_clr.rank[i] = W2Bits'(i);
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == ClrBits'(ClrSets - 1)) state_d = StIdle;
      end
      StIdle:  if (in_valid_i) state_d = StRd1;
      StRd1:   state_d = StCmp1;
      StCmp1:  state_d = hit1 ? StWr1 : StRd2;
      StRd2:   state_d = StWr2;
      StWr2:   state_d = vict_valid_q ? StRdV : StWr1;
      StRdV:   state_d = StWrV;
      StWrV:   state_d = StWr1;
      StWr1:   state_d = StOut;
      StOut:   if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == StOut && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
    end
  end

  // Memories and datapath registers. The status of the access in progress is
  // kept apart from the output register so that a waiting result stays put.
  always_ff @(posedge clk_i) begin
    if (state_q == StClear) begin
      if (clr_q < ClrBits'(L1_SETS)) l1_mem[S1Bits'(clr_q)] <= l1_clr;
      if (clr_q < ClrBits'(L2_SETS)) l2_mem[S2Bits'(clr_q)] <= l2_clr;
    end
    if (state_q == StIdle && in_valid_i) line_q <= in_line;
    if (state_q == StRd1) l1_rd_q <= l1_mem[set1];
    if (state_q == StCmp1) begin
      l1_new_q     <= l1_upd;
      vict_valid_q <= !hit1 && l1_rd_q.valid[vic_w];
      vict_line_q  <= l1_rd_q.line[vic_w];
      res_q        <= etl_pkg::StatusL1Hit;
    end
    if (state_q == StRd2 || state_q == StRdV) l2_rd_q <= l2_mem[(state_q == StRd2) ? set2 : setv];
    if (state_q == StWr2) begin
      l2_mem[set2] <= l2_inv;
      res_q        <= hit2 ? etl_pkg::StatusL2Hit : etl_pkg::StatusMiss;
    end
    if (state_q == StWrV) l2_mem[setv] <= l2_ins;
    if (state_q == StWr1) l1_mem[set1] <= l1_new_q;
    if (state_q == StOut && (!out_valid_q || out_ready_i)) status_q <= res_q;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

// ----- sv/etl_checker.sv -----
// Port-level checker for the cache tag store, bound to the top level.
module etl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [etl_pkg::StatusBits-1:0] status_o
);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == etl_pkg::StatusL1Hit || status_o == etl_pkg::StatusL2Hit ||
                     status_o == etl_pkg::StatusMiss))
    else $error("status out of range");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after a transfer");

  a_min_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o [*4])
    else $error("access finished in fewer than four cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind exclusive_two_level_lru_cache_top etl_checker u_etl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o)
);
